### sv/sht_pkg.sv
`default_nettype none
package sht_pkg;

    localparam int NAME_W    = 64;
    localparam int KEY_BYTES = 8;
    localparam int CNT_W     = 4;
    localparam int KIND_W    = 4;
    localparam int POS_W     = 11;
    localparam int SIZE_W    = 16;
    localparam int STAT_W    = 3;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_ENTER  = 2'd2,
        OP_LEAVE  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_BFULL    = 3'd4,
        ST_BEMPTY   = 3'd5
    } t_status;

endpackage
`default_nettype wire

### sv/scoped_hash_symbol_table_core.sv
`default_nettype none
// Operation: a lookup hashes the name, reads the bucket head and walks the chain one entry at
// a time; an insert walks the chain within the current block and then writes; enter, and leave
// at the global block, touch no entry; any other leave pops and rehashes each entry of the block.
// Throughput: one item at a time, the next taken once the result is set; the chain
// walk and the pop loop over the entry memory's single read port set the rate.
// Reset: synchronous, active low; then a pass over all HASH_BUCKETS entries sets every bucket
// head empty, during which no item is taken.
module scoped_hash_symbol_table_core #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int HASH_BUCKETS = 256,
    parameter int BLOCK_DEPTH  = 32,
    parameter int KEY_CHARS    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // op[1:0], name_key[65:2], kind[69:66], type_ref[80:70], byte_size[96:81]
    input  wire logic [103:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // status[2:0], position[13:3], kind_out[17:14], type_out[28:18], size_out[44:29]
    output logic [47:0]        m_axis_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    // signed, with room for a block start of TABLE_DEPTH on a full table
    localparam int PW = AW + 2;
    localparam int HW = $clog2(HASH_BUCKETS);
    localparam int BW = $clog2(BLOCK_DEPTH);
    localparam int NW = sht_pkg::NAME_W;
    localparam int KW = sht_pkg::KIND_W;
    localparam int TW = sht_pkg::POS_W;
    localparam int ZW = sht_pkg::SIZE_W;
    localparam int EW = NW + KW + TW + ZW + PW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_WALK, S_CHK, S_INS,
        S_POP_RD, S_POP_HS, S_POP_WAIT, S_LEAVE_RD, S_LEAVE_FIN, S_DONE
    } t_state;

    t_state                 r_state;
    sht_pkg::t_op           r_op;
    logic [NW-1:0]          r_key;
    logic [KW-1:0]          r_kind;
    logic [TW-1:0]          r_type;
    logic [ZW-1:0]          r_size;
    logic [HW-1:0]          r_bucket;
    logic [HW-1:0]          r_clr;
    logic signed [PW-1:0]   r_h;
    logic signed [PW-1:0]   r_head;
    logic signed [PW-1:0]   r_link;
    logic signed [PW-1:0]   r_top;
    logic signed [PW-1:0]   r_cur_start;
    logic [BW-1:0]          r_btop;
    logic [sht_pkg::STAT_W-1:0] r_res_stat;
    logic [TW-1:0]          r_res_pos;
    logic [KW-1:0]          r_res_kind;
    logic [TW-1:0]          r_res_type;
    logic [ZW-1:0]          r_res_size;
    logic                   r_ov;
    logic [47:0]            r_odata;

    logic [NW-1:0]          w_norm;
    logic                   w_live;
    logic                   w_accept;
    logic signed [PW-1:0]   w_newp;

    logic                   w_hstart;
    logic [NW-1:0]          w_hkey;
    logic                   w_hdone;
    logic [HW-1:0]          w_hbucket;

    logic                   w_bk_we;
    logic [HW-1:0]          w_bk_waddr;
    logic [PW-1:0]          w_bk_wdata;
    logic [HW-1:0]          w_bk_raddr;
    logic [PW-1:0]          w_bk_rdata;

    logic                   w_en_we;
    logic [AW-1:0]          w_en_waddr;
    logic [EW-1:0]          w_en_wdata;
    logic [AW-1:0]          w_en_raddr;
    logic [EW-1:0]          w_en_rdata;
    logic [NW-1:0]          w_e_name;
    logic [KW-1:0]          w_e_kind;
    logic [TW-1:0]          w_e_type;
    logic [ZW-1:0]          w_e_size;
    logic signed [PW-1:0]   w_e_link;

    logic                   w_bl_we;
    logic [BW-1:0]          w_bl_waddr;
    logic [BW-1:0]          w_bl_raddr;
    logic [PW-1:0]          w_bl_rdata;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign w_newp        = r_top + PW'(1);

    // name bytes up to the first zero or KEY_CHARS
    always_comb begin
        w_live = 1'b1;
        w_norm = '0;
        for (int i = 0; i < sht_pkg::KEY_BYTES; i++) begin
            if (i >= KEY_CHARS || s_axis_tdata[2+8*i +: 8] == 8'd0) begin
                w_live = 1'b0;
            end
            if (w_live) begin
                w_norm[8*i +: 8] = s_axis_tdata[2+8*i +: 8];
            end
        end
    end

    assign w_e_name = w_en_rdata[NW-1:0];
    assign w_e_kind = w_en_rdata[NW +: KW];
    assign w_e_type = w_en_rdata[NW+KW +: TW];
    assign w_e_size = w_en_rdata[NW+KW+TW +: ZW];
    assign w_e_link = w_en_rdata[NW+KW+TW+ZW +: PW];

    assign w_hstart = (w_accept && (s_axis_tdata[1:0] == sht_pkg::OP_INSERT
                                 || s_axis_tdata[1:0] == sht_pkg::OP_LOOKUP))
                   || (r_state == S_POP_HS);
    assign w_hkey   = (r_state == S_POP_HS) ? w_e_name : w_norm;

    always_comb begin
        w_bk_we    = 1'b0;
        w_bk_waddr = r_bucket;
        w_bk_wdata = w_newp;
        w_bk_raddr = w_hbucket;
        w_en_we    = 1'b0;
        w_en_waddr = w_newp[AW-1:0];
        w_en_wdata = {r_head, r_size, r_type, r_kind, r_key};
        w_en_raddr = r_h[AW-1:0];
        w_bl_we    = 1'b0;
        w_bl_waddr = r_btop + 1'b1;
        w_bl_raddr = r_btop - 1'b1;
        case (r_state)
            S_CLEAR: begin
                w_bk_we    = 1'b1;
                w_bk_waddr = r_clr;
                w_bk_wdata = '1;
            end
            S_IDLE: begin
                w_bl_we = w_accept && (s_axis_tdata[1:0] == sht_pkg::OP_ENTER)
                       && (r_btop != BW'(BLOCK_DEPTH - 1));
            end
            S_INS: begin
                w_bk_we = (r_top != PW'(TABLE_DEPTH - 1));
                w_en_we = w_bk_we;
            end
            S_POP_RD: begin
                w_en_raddr = r_top[AW-1:0];
            end
            S_POP_WAIT: begin
                w_bk_we    = w_hdone;
                w_bk_waddr = w_hbucket;
                w_bk_wdata = r_link;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_top       <= '1;
            r_cur_start <= '1;
            r_btop      <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (r_ov && m_axis_tready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == HW'(HASH_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op       <= sht_pkg::t_op'(s_axis_tdata[1:0]);
                        r_key      <= w_norm;
                        r_kind     <= s_axis_tdata[69:66];
                        r_type     <= s_axis_tdata[80:70];
                        r_size     <= s_axis_tdata[96:81];
                        r_res_stat <= sht_pkg::ST_OK;
                        r_res_pos  <= '1;
                        r_res_kind <= '0;
                        r_res_type <= '1;
                        r_res_size <= '0;
                        case (sht_pkg::t_op'(s_axis_tdata[1:0]))
                            sht_pkg::OP_ENTER: begin
                                r_state <= S_DONE;
                                if (r_btop == BW'(BLOCK_DEPTH - 1)) begin
                                    r_res_stat <= sht_pkg::ST_BFULL;
                                end else begin
                                    r_btop      <= r_btop + 1'b1;
                                    r_cur_start <= w_newp;
                                end
                            end
                            sht_pkg::OP_LEAVE: begin
                                if (r_btop == '0) begin
                                    r_res_stat <= sht_pkg::ST_BEMPTY;
                                    r_state    <= S_DONE;
                                end else begin
                                    r_state <= S_POP_RD;
                                end
                            end
                            default: r_state <= S_HASH;
                        endcase
                    end
                end
                S_HASH: begin
                    r_bucket <= w_hbucket;
                    if (w_hdone) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_h     <= w_bk_rdata;
                    r_head  <= w_bk_rdata;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (!r_h[PW-1] && (r_op == sht_pkg::OP_LOOKUP || r_h >= r_cur_start)) begin
                        r_state <= S_CHK;
                    end else if (r_op == sht_pkg::OP_LOOKUP) begin
                        r_res_stat <= sht_pkg::ST_NOTFOUND;
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_INS;
                    end
                end
                S_CHK: begin
                    if (w_e_name == r_key) begin
                        r_state <= S_DONE;
                        if (r_op == sht_pkg::OP_LOOKUP) begin
                            r_res_pos  <= TW'(r_h[AW-1:0]);
                            r_res_kind <= w_e_kind;
                            r_res_type <= w_e_type;
                            r_res_size <= w_e_size;
                        end else begin
                            r_res_stat <= sht_pkg::ST_DUP;
                        end
                    end else begin
                        r_h     <= w_e_link;
                        r_state <= S_WALK;
                    end
                end
                S_INS: begin
                    r_state <= S_DONE;
                    if (r_top == PW'(TABLE_DEPTH - 1)) begin
                        r_res_stat <= sht_pkg::ST_FULL;
                    end else begin
                        r_top     <= w_newp;
                        r_res_pos <= TW'(w_newp[AW-1:0]);
                    end
                end
                S_POP_RD: begin
                    if (!r_top[PW-1] && r_top >= r_cur_start) begin
                        r_state <= S_POP_HS;
                    end else begin
                        r_state <= S_LEAVE_RD;
                    end
                end
                S_POP_HS: begin
                    r_link  <= w_e_link;
                    r_state <= S_POP_WAIT;
                end
                S_POP_WAIT: begin
                    if (w_hdone) begin
                        r_top   <= r_top - PW'(1);
                        r_state <= S_POP_RD;
                    end
                end
                S_LEAVE_RD: begin
                    r_btop  <= r_btop - 1'b1;
                    r_state <= S_LEAVE_FIN;
                end
                S_LEAVE_FIN: begin
                    // the global block has no stored start
                    r_cur_start <= (r_btop == '0) ? '1 : w_bl_rdata;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_odata <= {3'd0, r_res_size, r_res_type, r_res_kind,
                                    r_res_pos, r_res_stat};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    sht_hash #(
        .HASH_BUCKETS(HASH_BUCKETS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hstart),
        .i_key    (w_hkey),
        .o_done   (w_hdone),
        .o_bucket (w_hbucket)
    );

    sht_ram #(.WIDTH(PW), .DEPTH(HASH_BUCKETS)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (w_bk_we),
        .i_waddr (w_bk_waddr),
        .i_wdata (w_bk_wdata),
        .i_raddr (w_bk_raddr),
        .o_rdata (w_bk_rdata)
    );

    sht_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_en_we),
        .i_waddr (w_en_waddr),
        .i_wdata (w_en_wdata),
        .i_raddr (w_en_raddr),
        .o_rdata (w_en_rdata)
    );

    sht_ram #(.WIDTH(PW), .DEPTH(BLOCK_DEPTH)) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (w_bl_we),
        .i_waddr (w_bl_waddr),
        .i_wdata (w_newp),
        .i_raddr (w_bl_raddr),
        .o_rdata (w_bl_rdata)
    );

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top >= -1 && r_top <= PW'(TABLE_DEPTH - 1))
        else $error("table top out of range");

    // the start is reloaded in the cycle after the block count drops to the global block
    a_global_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_btop == '0 && r_state != S_LEAVE_FIN) |-> (r_cur_start == '1))
        else $error("global block start not empty");

    a_start_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_start - PW'(1)) <= r_top)
        else $error("block start above table top");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("item taken while busy");

endmodule
`default_nettype wire

### sv/sht_ram.sv
`default_nettype none
module sht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/sht_hash.sv
`default_nettype none
// Bucket hash h = (3*h + c) mod HASH_BUCKETS, one char per cycle.
// Stops at the first zero byte or after all key bytes.
module sht_hash #(
    parameter int HASH_BUCKETS = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [sht_pkg::NAME_W-1:0]      i_key,
    output logic                                 o_done,
    output logic [$clog2(HASH_BUCKETS)-1:0]      o_bucket
);

    localparam int HW = $clog2(HASH_BUCKETS);
    localparam int SW = HW + 2;

    logic [HW-1:0]                    w_cmod [256];
    logic [sht_pkg::NAME_W-1:0]       r_key;
    logic [HW-1:0]                    r_h;
    logic [sht_pkg::CNT_W-1:0]        r_cnt;
    logic                             r_busy;
    logic                             w_end;
    logic [SW-1:0]                    w_sum;
    logic [SW-1:0]                    w_red;

    for (genvar gi = 0; gi < 256; gi++) begin : g_cmod
        localparam logic [HW-1:0] CM = HW'(gi % HASH_BUCKETS);
        assign w_cmod[gi] = CM;
    end

    assign w_end = (r_key[7:0] == 8'd0) || (r_cnt == sht_pkg::CNT_W'(sht_pkg::KEY_BYTES));

    // 3h + (c mod B) < 4B, so three conditional subtracts finish the reduction
    always_comb begin
        w_sum = {1'b0, r_h, 1'b0} + {2'b00, r_h} + {2'b00, w_cmod[r_key[7:0]]};
        w_red = w_sum;
        for (int i = 0; i < 3; i++) begin
            if (w_red >= SW'(HASH_BUCKETS)) begin
                w_red = w_red - SW'(HASH_BUCKETS);
            end
        end
    end

    assign o_done   = r_busy && w_end;
    assign o_bucket = r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
        if (i_start) begin
            r_key <= i_key;
            r_h   <= '0;
            r_cnt <= '0;
        end else if (r_busy && !w_end) begin
            r_key <= {8'd0, r_key[sht_pkg::NAME_W-1:8]};
            r_h   <= w_red[HW-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

endmodule
`default_nettype wire
